/* rtl/core/qoa_pkg.sv */
package qoa_pkg;

  localparam int FRAC_BITS_DEF    = 15;
  localparam int CORDIC_ITERS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int CW               = 32;
  localparam logic signed [CW-1:0] CORDIC_X0 = 32'sd163008218;

  localparam logic [1:0] FUNC_COMPOSE = 2'd0;
  localparam logic [1:0] FUNC_SET     = 2'd1;
  localparam logic [1:0] FUNC_IDENT   = 2'd2;
  localparam logic [1:0] FUNC_READ    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANG, ST_CORD, ST_AXIS, ST_SQ, ST_SQRT, ST_NDIV, ST_HAM, ST_MAT, ST_OUT
  } state_t;

  // operand codes: 0..3 stored s,x,y,z ; 4..7 built b0..b3
  typedef struct packed {
    logic [2:0] a;
    logic [2:0] b;
    logic       neg;
  } term_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    case (i)
      5'd0:    atan_val = 32'h20000000;
      5'd1:    atan_val = 32'h12E4051D;
      5'd2:    atan_val = 32'h09FB385B;
      5'd3:    atan_val = 32'h051111D4;
      5'd4:    atan_val = 32'h028B0D43;
      5'd5:    atan_val = 32'h0145D7E1;
      5'd6:    atan_val = 32'h00A2F61E;
      5'd7:    atan_val = 32'h00517C55;
      5'd8:    atan_val = 32'h0028BE53;
      5'd9:    atan_val = 32'h00145F2E;
      5'd10:   atan_val = 32'h000A2F98;
      5'd11:   atan_val = 32'h000517CC;
      5'd12:   atan_val = 32'h00028BE6;
      5'd13:   atan_val = 32'h000145F3;
      5'd14:   atan_val = 32'h0000A2F9;
      5'd15:   atan_val = 32'h0000517C;
      5'd16:   atan_val = 32'h000028BE;
      5'd17:   atan_val = 32'h0000145F;
      5'd18:   atan_val = 32'h00000A2F;
      5'd19:   atan_val = 32'h00000517;
      5'd20:   atan_val = 32'h0000028B;
      5'd21:   atan_val = 32'h00000145;
      5'd22:   atan_val = 32'h000000A2;
      5'd23:   atan_val = 32'h00000051;
      default: atan_val = 32'h0;
    endcase
  endfunction

  function automatic term_t ham_term(input logic [3:0] k);
    case (k)
      4'd0:    ham_term = '{a: 3'd4, b: 3'd0, neg: 1'b0};
      4'd1:    ham_term = '{a: 3'd5, b: 3'd1, neg: 1'b1};
      4'd2:    ham_term = '{a: 3'd6, b: 3'd2, neg: 1'b1};
      4'd3:    ham_term = '{a: 3'd7, b: 3'd3, neg: 1'b1};
      4'd4:    ham_term = '{a: 3'd1, b: 3'd4, neg: 1'b0};
      4'd5:    ham_term = '{a: 3'd5, b: 3'd0, neg: 1'b0};
      4'd6:    ham_term = '{a: 3'd6, b: 3'd3, neg: 1'b0};
      4'd7:    ham_term = '{a: 3'd7, b: 3'd2, neg: 1'b1};
      4'd8:    ham_term = '{a: 3'd2, b: 3'd4, neg: 1'b0};
      4'd9:    ham_term = '{a: 3'd6, b: 3'd0, neg: 1'b0};
      4'd10:   ham_term = '{a: 3'd7, b: 3'd1, neg: 1'b0};
      4'd11:   ham_term = '{a: 3'd5, b: 3'd3, neg: 1'b1};
      4'd12:   ham_term = '{a: 3'd3, b: 3'd4, neg: 1'b0};
      4'd13:   ham_term = '{a: 3'd7, b: 3'd0, neg: 1'b0};
      4'd14:   ham_term = '{a: 3'd5, b: 3'd2, neg: 1'b0};
      default: ham_term = '{a: 3'd6, b: 3'd1, neg: 1'b1};
    endcase
  endfunction

  function automatic term_t mat_term(input logic [4:0] k);
    case (k)
      5'd0:    mat_term = '{a: 3'd2, b: 3'd2, neg: 1'b1};
      5'd1:    mat_term = '{a: 3'd3, b: 3'd3, neg: 1'b1};
      5'd2:    mat_term = '{a: 3'd1, b: 3'd2, neg: 1'b0};
      5'd3:    mat_term = '{a: 3'd0, b: 3'd3, neg: 1'b1};
      5'd4:    mat_term = '{a: 3'd1, b: 3'd3, neg: 1'b0};
      5'd5:    mat_term = '{a: 3'd0, b: 3'd2, neg: 1'b0};
      5'd6:    mat_term = '{a: 3'd1, b: 3'd2, neg: 1'b0};
      5'd7:    mat_term = '{a: 3'd0, b: 3'd3, neg: 1'b0};
      5'd8:    mat_term = '{a: 3'd1, b: 3'd1, neg: 1'b1};
      5'd9:    mat_term = '{a: 3'd3, b: 3'd3, neg: 1'b1};
      5'd10:   mat_term = '{a: 3'd2, b: 3'd3, neg: 1'b0};
      5'd11:   mat_term = '{a: 3'd0, b: 3'd1, neg: 1'b1};
      5'd12:   mat_term = '{a: 3'd1, b: 3'd3, neg: 1'b0};
      5'd13:   mat_term = '{a: 3'd0, b: 3'd2, neg: 1'b1};
      5'd14:   mat_term = '{a: 3'd2, b: 3'd3, neg: 1'b0};
      5'd15:   mat_term = '{a: 3'd0, b: 3'd1, neg: 1'b0};
      5'd16:   mat_term = '{a: 3'd1, b: 3'd1, neg: 1'b1};
      default: mat_term = '{a: 3'd2, b: 3'd2, neg: 1'b1};
    endcase
  endfunction

endpackage

/* rtl/core/qoa_cordic.sv */
module qoa_cordic #(
  parameter int ITERS = qoa_pkg::CORDIC_ITERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [qoa_pkg::CW:0]     z_in,
  output logic                            done,
  output logic signed [qoa_pkg::CW-1:0]   x_out,
  output logic signed [qoa_pkg::CW-1:0]   y_out
);
  import qoa_pkg::*;

  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [CW:0]   z_r, z_nxt;
  logic [4:0]           i_r, i_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic signed [CW:0]   at;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    at       = signed'({1'b0, atan_val(i_r)});
    if (start) begin
      x_nxt    = CORDIC_X0;
      y_nxt    = '0;
      z_nxt    = z_in;
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[CW]) begin
        x_nxt = x_r - (y_r >>> i_r);
        y_nxt = y_r + (x_r >>> i_r);
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + (y_r >>> i_r);
        y_nxt = y_r - (x_r >>> i_r);
        z_nxt = z_r + at;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
endmodule

/* rtl/core/qoa_isqrt.sv */
module qoa_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt, trial;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = res_r + bit_r;
    if (start) begin
      v_nxt    = val;
      res_nxt  = '0;
      bit_nxt  = 64'h4000_0000_0000_0000;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];
endmodule

/* rtl/core/qoa_div.sv */
module qoa_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   n_r, n_nxt;
  logic [DW-1:0]   d_r, d_nxt, rem_r, rem_nxt;
  logic [DW:0]     rem_sh, diff;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt, ge;

  always_comb begin
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, n_r[NW-1]};
    diff     = rem_sh - {1'b0, d_r};
    ge       = rem_sh >= {1'b0, d_r};
    if (start) begin
      n_nxt    = num;
      d_nxt    = den;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      n_nxt   = {n_r[NW-2:0], ge};
      cnt_nxt = cnt_r + CNTW'(1);
      if (cnt_r == CNTW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = n_r;
endmodule

/* rtl/core/quaternion_orientation_accumulator.sv */
// Steps from input beat to out_valid for compose: angle scaling, CORDIC rotation, axis
// scaling, sum of squares, square root, four divides, Hamilton product, matrix. Set skips
// the Hamilton product; reset/read do only the matrix; zero magnitude skips the four divides.
// One beat at a time, ready only when idle: a new beat is taken only once the last result
// has been accepted, and a stalled result holds off the input.
// Synchronous active-low reset: quaternion returns to identity, no result pending.
module quaternion_orientation_accumulator #(
  parameter int FRAC_BITS    = qoa_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_ITERS = qoa_pkg::CORDIC_ITERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic signed [15:0]          in_angle_deg,
  input  logic signed [15:0]          in_axis_x,
  input  logic signed [15:0]          in_axis_y,
  input  logic signed [15:0]          in_axis_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+2:0] out_m00,
  output logic signed [FRAC_BITS+2:0] out_m01,
  output logic signed [FRAC_BITS+2:0] out_m02,
  output logic signed [FRAC_BITS+2:0] out_m10,
  output logic signed [FRAC_BITS+2:0] out_m11,
  output logic signed [FRAC_BITS+2:0] out_m12,
  output logic signed [FRAC_BITS+2:0] out_m20,
  output logic signed [FRAC_BITS+2:0] out_m21,
  output logic signed [FRAC_BITS+2:0] out_m22
);
  import qoa_pkg::*;

  localparam int QW    = FRAC_BITS + 3;
  localparam int NW    = FRAC_BITS + CW + 1;
  localparam int ITERS = (CORDIC_ITERS < ATAN_LEN) ? CORDIC_ITERS : ATAN_LEN;
  localparam logic signed [QW-1:0] Q_ONE = QW'(1) <<< FRAC_BITS;
  localparam logic [NW-1:0] R_HI  = NW'((64'd1 << (QW - 1)) - 64'd1);
  localparam logic [NW-1:0] R_MAG = NW'(64'd1 << (QW - 1));
  // h * 2^22 / 45 = 93206*h + (34*h)/45, second part by reciprocal
  localparam logic [63:0] ANG_INT   = 64'd93206;
  localparam logic [63:0] ANG_FRAC  = 64'd34;
  localparam logic [63:0] ANG_RECIP = 64'd2982617;
  localparam int          ANG_SHIFT = 27;

  function automatic logic signed [QW-1:0] rnd(input logic signed [63:0] v);
    logic signed [63:0] t, hi, lo;
    t  = (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    hi = (64'sd1 <<< (QW - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (QW - 1));
    if (t > hi) rnd = hi[QW-1:0];
    else if (t < lo) rnd = lo[QW-1:0];
    else rnd = t[QW-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic [1:0]              func_r, func_nxt;
  logic                    hneg_r, hneg_nxt, neg_r, neg_nxt;
  logic signed [15:0]      ax_r [3], ax_nxt [3];
  logic signed [QW-1:0]    st_r [4], st_nxt [4];
  logic signed [QW-1:0]    b_r [4], b_nxt [4];
  logic signed [QW-1:0]    n_r [4], n_nxt [4];
  logic signed [QW-1:0]    m_r [9], m_nxt [9];
  logic signed [CW-1:0]    q_r [4], q_nxt [4];
  logic signed [CW-1:0]    ycor_r, ycor_nxt;
  logic signed [63:0]      acc_r, acc_nxt;
  logic [31:0]             mag_r, mag_nxt;

  logic signed [CW-1:0]    opv [8];
  logic signed [CW-1:0]    mul_a, mul_b;
  logic signed [63:0]      prod, term_v, base;
  term_t                   tm;

  logic                    div_start, cor_start, sq_start, div_done, cor_done, sq_done;
  logic [NW-1:0]           div_num, quo;
  logic [31:0]             div_den, root, mag_sel;
  logic signed [CW:0]      cor_z;
  logic signed [CW-1:0]    cor_x, cor_y;
  logic [63:0]             sq_val;
  logic [63:0]             ang_full;
  logic [31:0]             a32, qabs;
  logic [1:0]              div_idx;
  logic [16:0]             habs;
  logic signed [QW-1:0]    bq;
  logic [3:0]              mj;

  qoa_div #(.NW(NW), .DW(32)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(quo)
  );

  qoa_cordic #(.ITERS(ITERS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .z_in(cor_z),
    .done(cor_done), .x_out(cor_x), .y_out(cor_y)
  );

  qoa_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .val(sq_val),
    .done(sq_done), .root(root)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      opv[i]     = CW'(st_r[i]);
      opv[i + 4] = CW'(b_r[i]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    func_nxt  = func_r;
    hneg_nxt  = hneg_r;
    neg_nxt   = neg_r;
    ax_nxt    = ax_r;
    st_nxt    = st_r;
    b_nxt     = b_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    q_nxt     = q_r;
    ycor_nxt  = ycor_r;
    acc_nxt   = acc_r;
    mag_nxt   = mag_r;
    div_start = 1'b0;
    cor_start = 1'b0;
    sq_start  = 1'b0;
    cor_z     = '0;
    sq_val    = '0;
    bq        = '0;
    ang_full  = '0;
    a32       = '0;
    mj        = cnt_r[4:1];
    habs      = in_angle_deg[15] ? 17'(-in_angle_deg) : 17'(in_angle_deg);
    tm        = (state_r == ST_HAM) ? ham_term(cnt_r[3:0]) : mat_term(cnt_r);
    mul_a     = opv[tm.a];
    mul_b     = opv[tm.b];
    if (state_r == ST_AXIS) begin
      mul_a = CW'(ax_r[cnt_r[1:0]]);
      mul_b = ycor_r;
    end else if (state_r == ST_SQ) begin
      mul_a = q_r[cnt_r[1:0]];
      mul_b = q_r[cnt_r[1:0]];
    end
    prod    = mul_a * mul_b;
    term_v  = (state_r == ST_MAT) ? (prod <<< 1) : prod;
    if (tm.neg) term_v = -term_v;
    base    = acc_r;
    if (state_r == ST_HAM && cnt_r[1:0] == 2'd0) base = '0;
    if (state_r == ST_MAT && !cnt_r[0]) begin
      base = (mj == 4'd0 || mj == 4'd4 || mj == 4'd8) ? (64'sd1 <<< (2 * FRAC_BITS)) : '0;
    end
    div_idx = (state_r == ST_SQRT) ? 2'd0 : 2'(cnt_r[1:0] + 2'd1);
    mag_sel = (state_r == ST_SQRT) ? root : mag_r;
    qabs    = q_r[div_idx][CW-1] ? 32'(-q_r[div_idx]) : 32'(q_r[div_idx]);
    div_num = (NW'(qabs) << FRAC_BITS) + NW'(mag_sel >> 1);
    div_den = mag_sel;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          hneg_nxt  = in_angle_deg[15];
          ax_nxt[0] = in_axis_x;
          ax_nxt[1] = in_axis_y;
          ax_nxt[2] = in_axis_z;
          cnt_nxt   = '0;
          if (in_func == FUNC_COMPOSE || in_func == FUNC_SET) begin
            mag_nxt   = 32'(habs);
            state_nxt = ST_ANG;
          end else begin
            if (in_func == FUNC_IDENT) begin
              st_nxt[0] = Q_ONE;
              st_nxt[1] = '0;
              st_nxt[2] = '0;
              st_nxt[3] = '0;
            end
            state_nxt = ST_MAT;
          end
        end
      end
      ST_ANG: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd0) begin
          acc_nxt = signed'(64'(mag_r) * ANG_FRAC);
        end else if (cnt_r == 5'd1) begin
          acc_nxt = signed'((unsigned'(acc_r) * ANG_RECIP) >> ANG_SHIFT);
        end else begin
          ang_full = 64'(mag_r) * ANG_INT + unsigned'(acc_r);
          a32      = hneg_r ? -ang_full[31:0] : ang_full[31:0];
          neg_nxt  = 1'b0;
          if (a32[31:30] == 2'd1 || a32[31:30] == 2'd2) begin
            a32     = a32 - 32'h8000_0000;
            neg_nxt = 1'b1;
          end
          cor_z     = (CW + 1)'(signed'(a32));
          cor_start = 1'b1;
          state_nxt = ST_CORD;
        end
      end
      ST_CORD: begin
        if (cor_done) begin
          q_nxt[0]  = neg_r ? -cor_x : cor_x;
          ycor_nxt  = neg_r ? -cor_y : cor_y;
          cnt_nxt   = '0;
          state_nxt = ST_AXIS;
        end
      end
      ST_AXIS: begin
        q_nxt[2'(cnt_r[1:0] + 2'd1)] = CW'(prod >>> 14);
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd2) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        acc_nxt = (cnt_r == 5'd0) ? prod : acc_r + prod;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd3) begin
          sq_val    = acc_nxt;
          sq_start  = 1'b1;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT, ST_NDIV: begin
        if (state_r == ST_SQRT && sq_done) begin
          mag_nxt = root;
          cnt_nxt = '0;
          if (root == 32'd0) begin
            b_nxt[0] = Q_ONE;
            b_nxt[1] = '0;
            b_nxt[2] = '0;
            b_nxt[3] = '0;
            cnt_nxt  = 5'd3;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_NDIV;
          end
        end else if (state_r == ST_NDIV && div_done) begin
          if (q_r[cnt_r[1:0]][CW-1]) bq = (quo > R_MAG) ? -Q_ONE <<< 2 : -quo[QW-1:0];
          else bq = (quo > R_HI) ? R_HI[QW-1:0] : quo[QW-1:0];
          b_nxt[cnt_r[1:0]] = bq;
          if (cnt_r != 5'd3) begin
            div_start = 1'b1;
            cnt_nxt   = cnt_r + 5'd1;
          end
        end
        if ((state_r == ST_SQRT && sq_done && root == 32'd0) ||
            (state_r == ST_NDIV && div_done && cnt_r == 5'd3)) begin
          cnt_nxt = '0;
          if (func_r == FUNC_SET) begin
            st_nxt    = b_nxt;
            state_nxt = ST_MAT;
          end else begin
            state_nxt = ST_HAM;
          end
        end
      end
      ST_HAM: begin
        acc_nxt = base + term_v;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[1:0] == 2'd3) n_nxt[cnt_r[3:2]] = rnd(acc_nxt);
        if (cnt_r == 5'd15) begin
          st_nxt    = n_nxt;
          cnt_nxt   = '0;
          state_nxt = ST_MAT;
        end
      end
      ST_MAT: begin
        acc_nxt = base + term_v;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r[0]) m_nxt[mj] = rnd(acc_nxt);
        if (cnt_r == 5'd17) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    func_r <= func_nxt;
    hneg_r <= hneg_nxt;
    neg_r  <= neg_nxt;
    ax_r   <= ax_nxt;
    b_r    <= b_nxt;
    n_r    <= n_nxt;
    m_r    <= m_nxt;
    q_r    <= q_nxt;
    ycor_r <= ycor_nxt;
    acc_r  <= acc_nxt;
    mag_r  <= mag_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      st_r[0] <= Q_ONE;
      st_r[1] <= '0;
      st_r[2] <= '0;
      st_r[3] <= '0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_m00   = m_r[0];
  assign out_m01   = m_r[1];
  assign out_m02   = m_r[2];
  assign out_m10   = m_r[3];
  assign out_m11   = m_r[4];
  assign out_m12   = m_r[5];
  assign out_m20   = m_r[6];
  assign out_m21   = m_r[7];
  assign out_m22   = m_r[8];
endmodule

/* tb/qoa_checker.sv */
module qoa_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_angle_deg,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [17:0] out_m00,
  input  logic signed [17:0] out_m01,
  input  logic signed [17:0] out_m02,
  input  logic signed [17:0] out_m10,
  input  logic signed [17:0] out_m11,
  input  logic signed [17:0] out_m12,
  input  logic signed [17:0] out_m20,
  input  logic signed [17:0] out_m21,
  input  logic signed [17:0] out_m22,
  output int                 errors,
  output int                 pending
);
  import qoa_pkg::*;

  localparam int FB = 15;
  localparam longint SAT_HI = (64'sd1 <<< (FB + 2)) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< (FB + 2));

  longint arctan_turns [24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  longint orient_s, orient_x, orient_y, orient_z;
  logic [9*18-1:0] matrix_q[$];
  int beat_no;

  function automatic longint clamp18(input longint v);
    return v > SAT_HI ? SAT_HI : (v < SAT_LO ? SAT_LO : v);
  endfunction

  function automatic longint round_q(input longint v);
    return clamp18((v + (64'sd1 <<< (FB - 1))) >>> FB);
  endfunction

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_div(input longint q, input longint mag);
    longint unsigned a, r;
    a = q < 0 ? -q : q;
    r = ((a << FB) + longint'(mag) / 2) / longint'(mag);
    return clamp18(q < 0 ? -longint'(r) : longint'(r));
  endfunction

  task automatic make_rotation(input logic signed [15:0] ang, ax, ay, az,
                               output longint b0, b1, b2, b3);
    longint h, zl, z, x, y, dx, dy, mag;
    longint q [4];
    longint unsigned sum;
    logic [31:0] turn;
    bit flip;
    h = ang;
    zl = h * 4194304 / 45;
    turn = zl[31:0];
    flip = 0;
    x = 163008218;
    y = 0;
    sum = 0;
    if (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) begin
      turn = turn - 32'h80000000;
      flip = 1;
    end
    z = $signed(turn);
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - arctan_turns[i];
      end else begin
        x = x + dx; y = y - dy; z = z + arctan_turns[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    q[0] = x;
    q[1] = (longint'(ax) * y) >>> 14;
    q[2] = (longint'(ay) * y) >>> 14;
    q[3] = (longint'(az) * y) >>> 14;
    for (int i = 0; i < 4; i++) sum = sum + longint'(q[i] * q[i]);
    mag = int_root(sum);
    if (mag == 0) begin
      b0 = 64'sd1 <<< FB; b1 = 0; b2 = 0; b3 = 0;
    end else begin
      b0 = unit_div(q[0], mag);
      b1 = unit_div(q[1], mag);
      b2 = unit_div(q[2], mag);
      b3 = unit_div(q[3], mag);
    end
  endtask

  function automatic logic [9*18-1:0] rot_matrix(input longint s, x, y, z);
    longint one;
    longint m [9];
    logic [9*18-1:0] packed_m;
    one = 64'sd1 <<< (2 * FB);
    m[0] = round_q(one - 2 * y * y - 2 * z * z);
    m[1] = round_q(2 * x * y - 2 * s * z);
    m[2] = round_q(2 * x * z + 2 * s * y);
    m[3] = round_q(2 * x * y + 2 * s * z);
    m[4] = round_q(one - 2 * x * x - 2 * z * z);
    m[5] = round_q(2 * y * z - 2 * s * x);
    m[6] = round_q(2 * x * z - 2 * s * y);
    m[7] = round_q(2 * y * z + 2 * s * x);
    m[8] = round_q(one - 2 * x * x - 2 * y * y);
    for (int k = 0; k < 9; k++) packed_m[k*18 +: 18] = m[k][17:0];
    return packed_m;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH beat %0d: %s", beat_no, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    longint b0, b1, b2, b3, s, x, y, z;
    logic [9*18-1:0] got, want;
    string names [9];
    names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
    if (!rst_n) begin
      orient_s = 64'sd1 <<< FB;
      orient_x = 0; orient_y = 0; orient_z = 0;
      matrix_q.delete();
      errors = 0;
      beat_no = 0;
    end else begin
      if (in_valid && in_ready) begin
        s = orient_s; x = orient_x; y = orient_y; z = orient_z;
        if (in_func == FUNC_COMPOSE || in_func == FUNC_SET) begin
          make_rotation(in_angle_deg, in_axis_x, in_axis_y, in_axis_z, b0, b1, b2, b3);
          if (in_func == FUNC_SET) begin
            s = b0; x = b1; y = b2; z = b3;
          end else begin
            s = round_q(b0 * orient_s - (b1 * orient_x + b2 * orient_y + b3 * orient_z));
            x = round_q(orient_x * b0 + b1 * orient_s + (b2 * orient_z - b3 * orient_y));
            y = round_q(orient_y * b0 + b2 * orient_s + (b3 * orient_x - b1 * orient_z));
            z = round_q(orient_z * b0 + b3 * orient_s + (b1 * orient_y - b2 * orient_x));
          end
        end else if (in_func == FUNC_IDENT) begin
          s = 64'sd1 <<< FB; x = 0; y = 0; z = 0;
        end
        orient_s = s; orient_x = x; orient_y = y; orient_z = z;
        matrix_q.push_back(rot_matrix(s, x, y, z));
      end
      if (out_valid && out_ready) begin
        got = {out_m22, out_m21, out_m20, out_m12, out_m11, out_m10, out_m02, out_m01, out_m00};
        if (matrix_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = matrix_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (got[k*18 +: 18] !== want[k*18 +: 18])
              report_mismatch($sformatf("%s got %0d want %0d", names[k],
                $signed(got[k*18 +: 18]), $signed(want[k*18 +: 18])));
        end
        beat_no++;
      end
    end
    pending = matrix_q.size();
  end

endmodule

/* tb/tb_quaternion_orientation_accumulator.sv */
module tb_quaternion_orientation_accumulator;
  import qoa_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, out_valid;
  logic out_ready = 1'b0;
  logic [1:0] in_func;
  logic signed [15:0] in_angle_deg, in_axis_x, in_axis_y, in_axis_z;
  logic signed [17:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  int errors, pending;
  int cyc = 0;
  int rdy_mode = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  quaternion_orientation_accumulator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_angle_deg(in_angle_deg), .in_axis_x(in_axis_x), .in_axis_y(in_axis_y),
    .in_axis_z(in_axis_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_m00(m00), .out_m01(m01), .out_m02(m02), .out_m10(m10), .out_m11(m11),
    .out_m12(m12), .out_m20(m20), .out_m21(m21), .out_m22(m22)
  );

  qoa_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_angle_deg(in_angle_deg), .in_axis_x(in_axis_x), .in_axis_y(in_axis_y),
    .in_axis_z(in_axis_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_m00(m00), .out_m01(m01), .out_m02(m02), .out_m10(m10), .out_m11(m11),
    .out_m12(m12), .out_m20(m20), .out_m21(m21), .out_m22(m22),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("quaternion_orientation_accumulator verification failed");
      $finish;
    end
  end

  // receiver stall pattern, mode redrawn at random from four patterns
  always @(posedge clk) begin
    if (cyc % 256 == 0) rdy_mode <= $urandom_range(0, 3);
    case (rdy_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (cyc % 8 < 5);
    endcase
  end

  task automatic send_beat(input logic [1:0] f, input logic [15:0] ang, ax, ay, az);
    in_valid <= 1'b1;
    in_func <= f;
    in_angle_deg <= ang;
    in_axis_x <= ax;
    in_axis_y <= ay;
    in_axis_z <= az;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [15:0] axis_val();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  initial begin
    int burst, pick;
    logic [15:0] ang;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_READ;
    in_angle_deg = '0;
    in_axis_x = '0;
    in_axis_y = '0;
    in_axis_z = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(FUNC_READ, 16'd0, 16'd0, 16'd0, 16'd0);
    send_beat(FUNC_SET, 16'd5760, 16'd16384, 16'd0, 16'd0);
    send_beat(FUNC_COMPOSE, 16'd5760, 16'd0, 16'd16384, 16'd0);
    send_beat(FUNC_COMPOSE, 16'd11520, 16'd0, 16'd0, 16'd16384);
    send_beat(FUNC_IDENT, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_beat(FUNC_SET, 16'(-23040), 16'(-16384), 16'(-16384), 16'(-16384));
    send_beat(FUNC_COMPOSE, 16'd23040, 16'd16384, 16'd16384, 16'd16384);
    // zero axis with cosine near zero: identity rotation
    send_beat(FUNC_SET, 16'd11520, 16'd0, 16'd0, 16'd0);
    send_beat(FUNC_COMPOSE, 16'(-11520), 16'd0, 16'd0, 16'd0);
    send_beat(FUNC_SET, 16'd0, 16'd0, 16'd0, 16'd0);
    // raw bits beyond the nominal range
    send_beat(FUNC_SET, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_beat(FUNC_COMPOSE, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_beat(FUNC_COMPOSE, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_beat(FUNC_COMPOSE, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF);
    send_beat(FUNC_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(FUNC_COMPOSE, 16'd17280, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_beat(FUNC_IDENT, 16'd0, 16'd0, 16'd0, 16'd0);
    send_beat(FUNC_COMPOSE, 16'd1, 16'd1, 16'd0, 16'd0);
    send_beat(FUNC_COMPOSE, 16'd14000, 16'd9000, 16'(-12000), 16'd3000);
    in_valid <= 1'b0;
    @(posedge clk);

    burst = $urandom_range(1, 30);
    for (int n = 0; n < 2000; n++) begin
      pick = $urandom_range(0, 99);
      ang = 16'($signed($urandom_range(0, 46080)) - 23040);
      if (pick < 50)
        send_beat(FUNC_COMPOSE, ang, axis_val(), axis_val(), axis_val());
      else if (pick < 65)
        send_beat(FUNC_SET, ang, axis_val(), axis_val(), axis_val());
      else if (pick < 77)
        send_beat(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
      else if (pick < 85)
        send_beat(FUNC_READ, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else if (pick < 90)
        send_beat(FUNC_IDENT, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_beat(FUNC_COMPOSE, ang, 16'($signed($urandom_range(0, 8)) - 4),
                  16'($signed($urandom_range(0, 8)) - 4), 16'd0);
      burst--;
      if (burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        burst = $urandom_range(1, 30);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("quaternion_orientation_accumulator verification clean");
    else
      $display("quaternion_orientation_accumulator verification failed");
    $finish;
  end

endmodule
